/* rtl/gopd_pkg.sv */
// Shared types, constants and helpers for the outline point decoder.
// Used by the parser, queue, engine, top level, checker and testbench; depends on nothing.
`default_nettype none

package gopd_pkg;

  // Storage sizing.
  localparam int MAX_POINTS = 64;
  localparam int RESULT_CAP = 64;
  localparam int PtrW       = $clog2(MAX_POINTS);
  localparam int CntW       = $clog2(MAX_POINTS + 1);
  localparam int CapW       = $clog2(RESULT_CAP + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FifoPtrW   = $clog2(FIFO_DEPTH);

  // Flag bits and coordinate codes (x view; y is the flag shifted right once).
  localparam logic [7:0] FLAG_REPEAT = 8'h08;
  localparam logic [7:0] COORD_MASK  = 8'h12;
  localparam logic [7:0] CODE_MINUS  = 8'h02;
  localparam logic [7:0] CODE_PLUS   = 8'h12;
  localparam logic [7:0] CODE_SAME   = 8'h10;
  localparam logic [7:0] CODE_LONG   = 8'h00;

  localparam logic signed [17:0] SUM_MIN = -18'sd65536;
  localparam logic signed [17:0] SUM_MAX = 18'sd65535;

  typedef enum logic [1:0] {
    KIND_END = 2'd0,
    KIND_X   = 2'd1,
    KIND_Y   = 2'd2,
    KIND_ERR = 2'd3
  } item_kind_e;

  typedef enum logic [1:0] {
    CMD_ITEM   = 2'd0,
    CMD_COORDS = 2'd1,
    CMD_BYTE   = 2'd2
  } cmd_kind_e;

  typedef enum logic [2:0] {
    FR_IDLE   = 3'd0,
    FR_ENDS   = 3'd1,
    FR_ILEN   = 3'd2,
    FR_SKIP   = 3'd3,
    FR_FLAGS  = 3'd4,
    FR_REPEAT = 3'd5,
    FR_FILL   = 3'd6,
    FR_COORD  = 3'd7
  } front_state_e;

  typedef enum logic [1:0] {
    AX_NONE = 2'd0,
    AX_X    = 2'd1,
    AX_Y    = 2'd2
  } axis_e;

  // Command passed from the parser to the coordinate engine.
  typedef struct packed {
    cmd_kind_e       kind;
    logic [7:0]      data_byte;
    logic            start;
    item_kind_e      item_kind;
    logic [9:0]      point_index;
    logic            last;
    logic [CntW-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

  typedef struct packed {
    logic            we;
    logic [PtrW-1:0] addr;
    logic [7:0]      data;
  } flag_wr_t;

  // Running sum with saturation to 17 bits signed.
  function automatic logic signed [16:0] sat_add(input logic signed [16:0] run,
                                                 input logic signed [16:0] delta);
    logic signed [17:0] s;
    s = $signed({run[16], run}) + $signed({delta[16], delta});
    if (s < SUM_MIN) begin
      return SUM_MIN[16:0];
    end else if (s > SUM_MAX) begin
      return SUM_MAX[16:0];
    end
    return s[16:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/gopd_in_if.sv */
// Input channel of the outline point decoder: one glyph body byte per transfer.
// Stands alone; no package needed.
`default_nettype none

interface gopd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       glyph_start;
  logic [9:0] contour_count;

  modport source(output valid, data_byte, glyph_start, contour_count, input ready);
  modport sink(input valid, data_byte, glyph_start, contour_count, output ready);
endinterface

`default_nettype wire

/* rtl/gopd_out_if.sv */
// Output channel of the outline point decoder: one decoded item per transfer.
// Stands alone; no package needed.
`default_nettype none

interface gopd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [9:0]         point_index;
  logic signed [17:0] coord_value;
  logic               on_curve;
  logic               last_of_glyph;

  modport source(output valid, item_kind, point_index, coord_value, on_curve,
                 last_of_glyph, input ready);
  modport sink(input valid, item_kind, point_index, coord_value, on_curve,
               last_of_glyph, output ready);
endinterface

`default_nettype wire

/* rtl/gopd_ram.sv */
// Generic single write port RAM with one registered read port.
// Stands alone; no package needed.
`default_nettype none

module gopd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/gopd_front.sv */
// Header and flag parser: contour ends, instruction skip, flag storage and runs.
// Depends on gopd_pkg and gopd_in_if; feeds the command queue and the flag RAM.
`default_nettype none

module gopd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  gopd_in_if.sink                    in_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output gopd_pkg::cmd_t             push_cmd_o,
  input  wire gopd_pkg::back_status_t status_i,
  output gopd_pkg::flag_wr_t         flag_wr_o
);
  import gopd_pkg::*;

  localparam int SumW = ((CntW > 8) ? CntW : 8) + 1;

  front_state_e    st_q, st_d;
  logic            bp_q, bp_d;
  logic [7:0]      high_q, high_d;
  logic [9:0]      contours_q, contours_d;
  logic [15:0]     last_end_q, last_end_d;
  logic [15:0]     skip_q, skip_d;
  logic [CntW-1:0] fcnt_q, fcnt_d;
  logic            has_pts_q, has_pts_d;
  logic [7:0]      last_flag_q, last_flag_d;
  logic [7:0]      fill_q, fill_d;

  logic            take;
  logic [7:0]      b;
  logic [15:0]     word;
  logic [16:0]     end_plus1;
  logic [CntW-1:0] fcnt_inc;
  logic            full_q_done;
  logic            inc_done;
  logic            rep_bad;
  logic            pts_full;
  logic            wait_quiet;

  assign b           = in_i.data_byte;
  assign word        = {high_q, b};
  assign end_plus1   = {1'b0, last_end_q} + 17'd1;
  assign fcnt_inc    = fcnt_q + CntW'(1);
  assign full_q_done = (17'(fcnt_q) >= end_plus1);
  assign inc_done    = (17'(fcnt_inc) >= end_plus1);
  assign rep_bad     = (fcnt_q == '0) ||
                       ((SumW'(fcnt_q) + SumW'(b)) > SumW'(MAX_POINTS));
  assign pts_full    = (fcnt_q >= CntW'(MAX_POINTS));

  // Flag writes wait until the coordinate engine has let go of the previous glyph.
  assign wait_quiet  = ((st_q == FR_FLAGS) || (st_q == FR_REPEAT)) && !status_i.idle;
  assign in_i.ready  = push_ready_i && (st_q != FR_FILL) && !wait_quiet;
  assign take        = in_i.valid && in_i.ready;

  // Next state and parser registers.
  always_comb begin
    st_d        = st_q;
    bp_d        = bp_q;
    high_d      = high_q;
    contours_d  = contours_q;
    last_end_d  = last_end_q;
    skip_d      = skip_q;
    fcnt_d      = fcnt_q;
    has_pts_d   = has_pts_q;
    last_flag_d = last_flag_q;
    fill_d      = fill_q;
    if (take && in_i.glyph_start) begin
      bp_d       = 1'b1;
      high_d     = b;
      contours_d = in_i.contour_count;
      has_pts_d  = (in_i.contour_count != '0);
      last_end_d = '0;
      skip_d     = '0;
      fcnt_d     = '0;
      st_d       = (in_i.contour_count != '0) ? FR_ENDS : FR_ILEN;
    end else if (take) begin
      unique case (st_q)
        FR_ENDS: begin
          if (!bp_q) begin
            high_d = b;
            bp_d   = 1'b1;
          end else begin
            bp_d       = 1'b0;
            last_end_d = word;
            contours_d = contours_q - 10'd1;
            if (contours_q == 10'd1) begin
              st_d = FR_ILEN;
            end
          end
        end
        FR_ILEN: begin
          if (!bp_q) begin
            high_d = b;
            bp_d   = 1'b1;
          end else begin
            bp_d   = 1'b0;
            skip_d = word;
            if (word == '0) begin
              st_d   = has_pts_q ? FR_FLAGS : FR_IDLE;
              fcnt_d = '0;
            end else begin
              st_d = FR_SKIP;
            end
          end
        end
        FR_SKIP: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) begin
            st_d   = has_pts_q ? FR_FLAGS : FR_IDLE;
            fcnt_d = '0;
          end
        end
        FR_FLAGS: begin
          if (pts_full) begin
            st_d = FR_IDLE;
          end else begin
            last_flag_d = b;
            fcnt_d      = fcnt_inc;
            if ((b & FLAG_REPEAT) != '0) begin
              st_d = FR_REPEAT;
            end else if (inc_done) begin
              st_d = FR_COORD;
            end
          end
        end
        FR_REPEAT: begin
          if (rep_bad) begin
            st_d = FR_IDLE;
          end else if (b == '0) begin
            st_d = full_q_done ? FR_COORD : FR_FLAGS;
          end else begin
            fill_d = b;
            st_d   = FR_FILL;
          end
        end
        default: begin
        end
      endcase
    end else if ((st_q == FR_FILL) && push_ready_i) begin
      // Repeat run: one copy of the last flag per cycle while the queue can take a push.
      fcnt_d = fcnt_inc;
      fill_d = fill_q - 8'd1;
      if (fill_q == 8'd1) begin
        st_d = inc_done ? FR_COORD : FR_FLAGS;
      end
    end
  end

  // Queue pushes and flag RAM writes.
  always_comb begin
    push_valid_o = 1'b0;
    push_cmd_o   = '{kind: CMD_BYTE, data_byte: b, start: in_i.glyph_start,
                     item_kind: KIND_END, point_index: '0, last: 1'b0, count: '0};
    flag_wr_o    = '{we: 1'b0, addr: fcnt_q[PtrW-1:0], data: b};
    if (take && in_i.glyph_start) begin
      push_valid_o = (st_q == FR_COORD);
    end else if (take) begin
      unique case (st_q)
        FR_ENDS: begin
          if (bp_q) begin
            push_valid_o           = 1'b1;
            push_cmd_o.kind        = CMD_ITEM;
            push_cmd_o.point_index = word[9:0];
          end
        end
        FR_FLAGS: begin
          if (pts_full) begin
            push_valid_o           = 1'b1;
            push_cmd_o.kind        = CMD_ITEM;
            push_cmd_o.item_kind   = KIND_ERR;
            push_cmd_o.point_index = 10'(fcnt_q);
            push_cmd_o.last        = 1'b1;
          end else begin
            flag_wr_o.we = 1'b1;
            if (((b & FLAG_REPEAT) == '0) && inc_done) begin
              push_valid_o     = 1'b1;
              push_cmd_o.kind  = CMD_COORDS;
              push_cmd_o.count = fcnt_inc;
            end
          end
        end
        FR_REPEAT: begin
          if (rep_bad) begin
            push_valid_o           = 1'b1;
            push_cmd_o.kind        = CMD_ITEM;
            push_cmd_o.item_kind   = KIND_ERR;
            push_cmd_o.point_index = 10'(fcnt_q);
            push_cmd_o.last        = 1'b1;
          end else if ((b == '0) && full_q_done) begin
            push_valid_o     = 1'b1;
            push_cmd_o.kind  = CMD_COORDS;
            push_cmd_o.count = fcnt_q;
          end
        end
        FR_COORD: begin
          push_valid_o = 1'b1;
        end
        default: begin
        end
      endcase
    end else if ((st_q == FR_FILL) && push_ready_i) begin
      flag_wr_o.we   = 1'b1;
      flag_wr_o.data = last_flag_q;
      if ((fill_q == 8'd1) && inc_done) begin
        push_valid_o     = 1'b1;
        push_cmd_o.kind  = CMD_COORDS;
        push_cmd_o.count = fcnt_inc;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= FR_IDLE;
      bp_q       <= 1'b0;
      contours_q <= '0;
      last_end_q <= '0;
      skip_q     <= '0;
      fcnt_q     <= '0;
      has_pts_q  <= 1'b0;
      fill_q     <= '0;
    end else begin
      st_q       <= st_d;
      bp_q       <= bp_d;
      contours_q <= contours_d;
      last_end_q <= last_end_d;
      skip_q     <= skip_d;
      fcnt_q     <= fcnt_d;
      has_pts_q  <= has_pts_d;
      fill_q     <= fill_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    high_q      <= high_d;
    last_flag_q <= last_flag_d;
  end

endmodule

`default_nettype wire

/* rtl/gopd_cmd_fifo.sv */
// Short command queue between the parser and the coordinate engine.
// Depends on gopd_pkg for the command type and depth.
`default_nettype none

module gopd_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire gopd_pkg::cmd_t push_cmd_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output gopd_pkg::cmd_t      pop_cmd_o
);
  import gopd_pkg::*;

  cmd_t                entry_q [FIFO_DEPTH];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != (FifoPtrW + 1)'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = entry_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + FifoPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (FifoPtrW + 1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (FifoPtrW + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/gopd_back.sv */
// Coordinate engine: decodes x and y deltas against stored flags, drains
// byteless points, counts items per transfer and holds the output register.
// Depends on gopd_pkg and gopd_out_if; reads the flag RAM.
`default_nettype none

module gopd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire gopd_pkg::cmd_t cmd_i,
  output logic [gopd_pkg::PtrW-1:0] flag_raddr_o,
  input  wire logic [7:0]     flag_rdata_i,
  output gopd_pkg::back_status_t status_o,
  gopd_out_if.source          out_o
);
  import gopd_pkg::*;

  axis_e              axis_q, axis_d;
  logic               bp_q, bp_d;
  logic [7:0]         high_q, high_d;
  logic [PtrW-1:0]    idx_q, idx_d;
  logic signed [16:0] run_q, run_d;
  logic [CntW-1:0]    fcnt_q, fcnt_d;
  logic [CapW-1:0]    cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [7:0]         pbyte_q, pbyte_d;
  logic               pstart_q, pstart_d;

  logic               ov_q, ov_d;
  logic [1:0]         okind_q, okind_d;
  logic [9:0]         oidx_q, oidx_d;
  logic signed [17:0] oval_q, oval_d;
  logic               oon_q, oon_d;
  logic               olast_q, olast_d;

  logic               can_emit, in_xy, byteless, drain_go, cap_left;
  logic [7:0]         code;
  logic               act_pop, proc, proc_start, proc_ok;
  logic [7:0]         proc_b;
  logic               take, finish, do_finish;
  logic signed [16:0] delta, sum;
  logic               pt_last;

  assign can_emit = !ov_q || out_o.ready;
  assign in_xy    = (axis_q != AX_NONE);
  assign code     = (axis_q == AX_Y) ? ((flag_rdata_i >> 1) & COORD_MASK)
                                     : (flag_rdata_i & COORD_MASK);
  assign byteless = in_xy && (code == CODE_SAME);
  assign cap_left = (cnt_q < CapW'(RESULT_CAP));
  assign drain_go = byteless && cap_left;

  // A new command is taken only when nothing of the current transfer is left.
  assign act_pop     = !drain_go && !pend_q && cmd_valid_i;
  assign cmd_ready_o = can_emit && !drain_go && !pend_q;

  // A byte is decoded now, or parked while byteless points drain ahead of it.
  assign proc       = pend_q ? !drain_go
                             : (act_pop && (cmd_i.kind == CMD_BYTE) && !byteless);
  assign proc_start = pend_q ? pstart_q : cmd_i.start;
  assign proc_b     = pend_q ? pbyte_q : cmd_i.data_byte;
  assign proc_ok    = pend_q ? cap_left : 1'b1;
  assign take       = proc && !proc_start && proc_ok && in_xy;
  assign finish     = take && ((code == CODE_MINUS) || (code == CODE_PLUS) ||
                               ((code == CODE_LONG) && bp_q));
  assign do_finish  = drain_go || finish;

  // Delta of the point being finished.
  always_comb begin
    if (drain_go) begin
      delta = '0;
    end else if (code == CODE_MINUS) begin
      delta = -$signed({9'd0, proc_b});
    end else if (code == CODE_PLUS) begin
      delta = $signed({9'd0, proc_b});
    end else begin
      delta = 17'($signed({high_q, proc_b}));
    end
  end

  assign sum     = sat_add(run_q, delta);
  assign pt_last = ((CntW'(idx_q) + CntW'(1)) >= fcnt_q);

  // Engine registers.
  always_comb begin
    axis_d   = axis_q;
    bp_d     = bp_q;
    high_d   = high_q;
    idx_d    = idx_q;
    run_d    = run_q;
    fcnt_d   = fcnt_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    pbyte_d  = pbyte_q;
    pstart_d = pstart_q;
    if (can_emit) begin
      if (pend_q && !drain_go) begin
        pend_d = 1'b0;
      end
      if (act_pop) begin
        cnt_d = '0;
        unique case (cmd_i.kind)
          CMD_COORDS: begin
            axis_d = AX_X;
            idx_d  = '0;
            run_d  = '0;
            bp_d   = 1'b0;
            fcnt_d = cmd_i.count;
          end
          CMD_BYTE: begin
            if (byteless) begin
              pend_d   = 1'b1;
              pbyte_d  = cmd_i.data_byte;
              pstart_d = cmd_i.start;
            end
          end
          default: begin
          end
        endcase
      end
      if (proc && proc_start) begin
        axis_d = AX_NONE;
        bp_d   = 1'b0;
      end
      if (take && (code == CODE_LONG) && !bp_q) begin
        high_d = proc_b;
        bp_d   = 1'b1;
      end
      if (do_finish) begin
        bp_d  = 1'b0;
        cnt_d = (act_pop ? '0 : cnt_q) + CapW'(1);
        if (pt_last) begin
          idx_d  = '0;
          run_d  = '0;
          axis_d = (axis_q == AX_Y) ? AX_NONE : AX_Y;
        end else begin
          idx_d = idx_q + PtrW'(1);
          run_d = sum;
        end
      end
    end
  end

  // Output register.
  always_comb begin
    ov_d    = ov_q;
    okind_d = okind_q;
    oidx_d  = oidx_q;
    oval_d  = oval_q;
    oon_d   = oon_q;
    olast_d = olast_q;
    if (can_emit) begin
      ov_d = 1'b0;
      if (do_finish) begin
        ov_d    = 1'b1;
        okind_d = (axis_q == AX_Y) ? KIND_Y : KIND_X;
        oidx_d  = 10'(idx_q);
        oval_d  = 18'(sum);
        oon_d   = flag_rdata_i[0];
        olast_d = (axis_q == AX_Y) && pt_last;
      end else if (act_pop && (cmd_i.kind == CMD_ITEM)) begin
        ov_d    = 1'b1;
        okind_d = cmd_i.item_kind;
        oidx_d  = cmd_i.point_index;
        oval_d  = '0;
        oon_d   = 1'b0;
        olast_d = cmd_i.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AX_NONE;
      bp_q   <= 1'b0;
      idx_q  <= '0;
      run_q  <= '0;
      fcnt_q <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      axis_q <= axis_d;
      bp_q   <= bp_d;
      idx_q  <= idx_d;
      run_q  <= run_d;
      fcnt_q <= fcnt_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    high_q   <= high_d;
    pbyte_q  <= pbyte_d;
    pstart_q <= pstart_d;
    okind_q  <= okind_d;
    oidx_q   <= oidx_d;
    oval_q   <= oval_d;
    oon_q    <= oon_d;
    olast_q  <= olast_d;
  end

  // The RAM is addressed with the next point so its flag is ready in time.
  assign flag_raddr_o        = idx_d;
  assign status_o.idle       = (axis_q == AX_NONE) && !pend_q && !cmd_valid_i;
  assign out_o.valid         = ov_q;
  assign out_o.item_kind     = okind_q;
  assign out_o.point_index   = oidx_q;
  assign out_o.coord_value   = oval_q;
  assign out_o.on_curve      = oon_q;
  assign out_o.last_of_glyph = olast_q;

endmodule

`default_nettype wire

/* rtl/glyph_outline_point_decoder_unit.sv */
// Top level of the outline point decoder: parser, command queue, flag RAM and
// coordinate engine. Depends on gopd_pkg, both channel interfaces and all submodules.
//
//   Channel | Direction | Payload                                            | Unit
//   in_i    | sink      | data_byte, glyph_start, contour_count              | one body byte
//   out_o   | source    | item_kind, point_index, coord_value, on_curve, last | one item
//
// One byte is accepted per cycle while the queue has room and no repeat run or flag
// wait holds the input; the coordinate engine drains byteless points after a byte.
// Repeat count copies enter the flag RAM one per cycle while the queue has room.
// The first flag byte of a glyph waits until the engine has finished the previous
// glyph's points. Reset is asynchronous and active low; the flag RAM is not cleared.
// Either side may stall: a four entry queue and the output register decouple them.
`default_nettype none

module glyph_outline_point_decoder_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gopd_in_if.sink    in_i,
  gopd_out_if.source out_o
);
  import gopd_pkg::*;

  logic         push_valid, push_ready, pop_valid, pop_ready;
  cmd_t         push_cmd, pop_cmd;
  back_status_t status;
  flag_wr_t     flag_wr;
  logic [PtrW-1:0] flag_raddr;
  logic [7:0]      flag_rdata;

  gopd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd),
    .status_i     (status),
    .flag_wr_o    (flag_wr)
  );

  gopd_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  gopd_ram #(
    .Width (8),
    .Depth (MAX_POINTS)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (flag_wr.we),
    .waddr_i (flag_wr.addr),
    .wdata_i (flag_wr.data),
    .raddr_i (flag_raddr),
    .rdata_o (flag_rdata)
  );

  gopd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (pop_valid),
    .cmd_ready_o  (pop_ready),
    .cmd_i        (pop_cmd),
    .flag_raddr_o (flag_raddr),
    .flag_rdata_i (flag_rdata),
    .status_o     (status),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

/* rtl/gopd_checker.sv */
// Port level checks on the outline point decoder's output channel.
// Depends on gopd_pkg; bound to glyph_outline_point_decoder_unit below.
`default_nettype none

module gopd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [1:0]         item_kind_i,
  input wire logic [9:0]         point_index_i,
  input wire logic signed [17:0] coord_value_i,
  input wire logic               on_curve_i,
  input wire logic               last_of_glyph_i
);
  import gopd_pkg::*;

  // A stalled item holds its kind, index, value and last flag until the transfer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(item_kind_i) &&
      $stable(point_index_i) && $stable(coord_value_i) && $stable(last_of_glyph_i))
    else $error("output payload changed while stalled");

  // Contour ends and errors carry no coordinate and no curve bit.
  a_no_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (item_kind_i == KIND_END || item_kind_i == KIND_ERR) |->
      coord_value_i == '0 && !on_curve_i)
    else $error("non-coordinate item with coordinate payload");

  // An error always closes the glyph.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && item_kind_i == KIND_ERR |-> last_of_glyph_i)
    else $error("error item without end of glyph");

  // Only a y coordinate or an error closes a glyph.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_of_glyph_i |-> item_kind_i == KIND_Y || item_kind_i == KIND_ERR)
    else $error("end of glyph on wrong item kind");

endmodule

bind glyph_outline_point_decoder_unit gopd_checker u_gopd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .item_kind_i     (out_o.item_kind),
  .point_index_i   (out_o.point_index),
  .coord_value_i   (out_o.coord_value),
  .on_curve_i      (out_o.on_curve),
  .last_of_glyph_i (out_o.last_of_glyph)
);

`default_nettype wire

/* tb/sv/glyph_outline_point_decoder_unit_tb.sv */
// Self-checking testbench for the outline point decoder, with random stall on both channels.
// Depends on gopd_pkg, gopd_in_if, gopd_out_if and glyph_outline_point_decoder_unit.
// Each accepted byte runs through a behavioural decoder, and every item that comes out is checked.
`timescale 1ns / 1ps

module glyph_outline_point_decoder_unit_tb;
  import gopd_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int RandomBytes = 250;

  typedef enum logic [2:0] {
    DP_IDLE, DP_ENDS, DP_ILEN, DP_SKIP, DP_FLAGS, DP_REPEAT, DP_XC, DP_YC
  } dec_phase_e;

  typedef struct packed {
    item_kind_e         kind;
    logic [9:0]         idx;
    logic signed [17:0] val;
    logic               on;
    logic               is_last;
  } point_item_t;

  logic clk;
  logic rst_n;
  gopd_in_if  in_if();
  gopd_out_if out_if();

  glyph_outline_point_decoder_unit u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_item_t expected_items[$];
  int          mismatches;
  int          cycles;
  int          bytes_sent;
  bit          no_idle;
  logic [7:0]  body_q[$];

  // Decoder state as the block should hold it.
  dec_phase_e  ph;
  bit          hi_pending;
  int unsigned pend_hi, contours_left, last_end, skip_left, flag_cnt, coord_idx;
  int          run_val;
  bit          has_pts;
  logic [7:0]  flag_mem[MAX_POINTS];
  int          step_items;

  function automatic logic [7:0] flag_at();
    if (coord_idx < flag_cnt && coord_idx < MAX_POINTS) begin
      return flag_mem[coord_idx];
    end
    return 8'h00;
  endfunction

  // Coordinate code of the current point in the x view.
  function automatic logic [7:0] coord_code();
    logic [7:0] f;
    f = flag_at();
    return (ph == DP_XC) ? (f & COORD_MASK) : ((f >> 1) & COORD_MASK);
  endfunction

  task automatic emit(input item_kind_e k, input int unsigned idx, input int v,
                      input bit on, input bit is_last);
    point_item_t it;
    if (step_items >= RESULT_CAP) begin
      return;
    end
    it.kind = k;
    it.idx = idx[9:0];
    it.val = v[17:0];
    it.on = on;
    it.is_last = is_last;
    expected_items.insert(expected_items.size(), it);
    step_items++;
  endtask

  task automatic finish_coord(input int delta);
    int v;
    bit is_y;
    v = run_val + delta;
    is_y = (ph == DP_YC);
    if (v < -65536) begin
      v = -65536;
    end
    if (v > 65535) begin
      v = 65535;
    end
    run_val = v;
    emit(is_y ? KIND_Y : KIND_X, coord_idx, v, 1'(flag_at() & 8'h01),
         is_y && (coord_idx + 1 >= flag_cnt));
    hi_pending = 0;
    coord_idx++;
    if (coord_idx >= flag_cnt) begin
      coord_idx = 0;
      run_val = 0;
      ph = is_y ? DP_IDLE : DP_YC;
    end
  endtask

  task automatic drain_byteless();
    while (step_items < RESULT_CAP && (ph == DP_XC || ph == DP_YC) &&
           coord_code() == CODE_SAME) begin
      finish_coord(0);
    end
  endtask

  task automatic raise_overflow();
    emit(KIND_ERR, flag_cnt, 0, 1'b0, 1'b1);
    ph = DP_IDLE;
  endtask

  task automatic body_after_skip();
    if (has_pts) begin
      ph = DP_FLAGS;
      flag_cnt = 0;
    end else begin
      ph = DP_IDLE;
    end
  endtask

  task automatic check_flags_done();
    if (flag_cnt >= last_end + 1) begin
      ph = DP_XC;
      coord_idx = 0;
      run_val = 0;
      hi_pending = 0;
    end else begin
      ph = DP_FLAGS;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] w;
    logic [7:0]  code;
    case (ph)
      DP_ENDS, DP_ILEN: begin
        if (!hi_pending) begin
          pend_hi = b;
          hi_pending = 1;
        end else begin
          hi_pending = 0;
          w = {pend_hi[7:0], b};
          if (ph == DP_ENDS) begin
            last_end = w;
            emit(KIND_END, last_end, 0, 1'b0, 1'b0);
            contours_left = (contours_left - 1) & 10'h3FF;
            if (contours_left == 0) begin
              ph = DP_ILEN;
            end
          end else begin
            skip_left = w;
            if (skip_left == 0) begin
              body_after_skip();
            end else begin
              ph = DP_SKIP;
            end
          end
        end
      end
      DP_SKIP: begin
        skip_left--;
        if (skip_left == 0) begin
          body_after_skip();
        end
      end
      DP_FLAGS: begin
        if (flag_cnt >= MAX_POINTS) begin
          raise_overflow();
        end else begin
          flag_mem[flag_cnt] = b;
          flag_cnt++;
          if ((b & FLAG_REPEAT) != 0) begin
            ph = DP_REPEAT;
          end else begin
            check_flags_done();
          end
        end
      end
      DP_REPEAT: begin
        if (flag_cnt == 0 || flag_cnt + b > MAX_POINTS) begin
          raise_overflow();
        end else begin
          for (int i = 0; i < b; i++) begin
            flag_mem[flag_cnt + i] = flag_mem[flag_cnt - 1];
          end
          flag_cnt += b;
          check_flags_done();
        end
      end
      DP_XC, DP_YC: begin
        code = coord_code();
        if (code == CODE_MINUS) begin
          finish_coord(-int'(b));
        end else if (code == CODE_PLUS) begin
          finish_coord(int'(b));
        end else if (code == CODE_LONG) begin
          if (!hi_pending) begin
            pend_hi = b;
            hi_pending = 1;
          end else begin
            w = {pend_hi[7:0], b};
            finish_coord(int'($signed(w)));
          end
        end
      end
      default: ;
    endcase
  endtask

  // Works out the items caused by one accepted byte.
  task automatic decode_transfer(input logic [7:0] b, input logic st, input logic [9:0] cc);
    step_items = 0;
    drain_byteless();
    if (st) begin
      hi_pending = 0;
      pend_hi = 0;
      last_end = 0;
      skip_left = 0;
      flag_cnt = 0;
      coord_idx = 0;
      run_val = 0;
      contours_left = cc;
      has_pts = (cc != 0);
      ph = has_pts ? DP_ENDS : DP_ILEN;
      parse_byte(b);
    end else if (step_items < RESULT_CAP) begin
      parse_byte(b);
    end
    drain_byteless();
  endtask

  // Sends one byte after a random gap and predicts once it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic st, input logic [9:0] cc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.glyph_start <= st;
    in_if.contour_count <= cc;
    do @(posedge clk); while (!in_if.ready);
    decode_transfer(b, st, cc);
    bytes_sent++;
  endtask

  // Sends the body held in body_q, stopping after at most cut bytes.
  task automatic send_body(input logic [9:0] ncont, input int cut);
    for (int i = 0; i < body_q.size() && i < cut; i++) begin
      send_byte(body_q[i], i == 0, (i == 0) ? ncont : 10'($urandom_range(0, 1023)));
    end
  endtask

  // Appends one byte to the body under construction.
  task automatic add_body_byte(input logic [7:0] v);
    body_q.insert(body_q.size(), v);
  endtask

  // Builds a well-formed glyph body. A forced flag below 0 means random flags;
  // extreme mode uses the largest long deltas, positive for x and negative for y.
  task automatic build_glyph(input int npts, input int ncont, input int ilen,
                             input int rep_pct, input int forced, input bit extreme);
    logic [7:0] flist[$];
    logic [7:0] f, code;
    int cnt, r, hi;
    body_q.delete();
    for (int k = 0; k < ncont; k++) begin
      r = (k == ncont - 1) ? npts - 1 : $urandom_range(0, npts - 1);
      add_body_byte(r[15:8]);
      add_body_byte(r[7:0]);
    end
    add_body_byte(ilen[15:8]);
    add_body_byte(ilen[7:0]);
    repeat (ilen) add_body_byte(8'($urandom_range(0, 255)));
    if (ncont == 0) begin
      return;
    end
    cnt = 0;
    while (cnt < npts) begin
      f = (forced >= 0) ? 8'(forced) : 8'($urandom_range(0, 255)) & ~FLAG_REPEAT;
      if (forced >= 0 || ($urandom_range(1, 100) <= rep_pct && cnt + 1 < MAX_POINTS)) begin
        f = f | FLAG_REPEAT;
        hi = MAX_POINTS - cnt - 1;
        if (hi > npts - cnt + 2) begin
          hi = npts - cnt + 2;
        end
        if (hi > 255) begin
          hi = 255;
        end
        r = (forced >= 0) ? hi : $urandom_range(0, hi);
        add_body_byte(f);
        add_body_byte(r[7:0]);
        repeat (r + 1) flist.insert(flist.size(), f);
        cnt += r + 1;
      end else begin
        add_body_byte(f);
        flist.insert(flist.size(), f);
        cnt++;
      end
    end
    for (int ax = 0; ax < 2; ax++) begin
      foreach (flist[i]) begin
        code = (ax == 0) ? (flist[i] & COORD_MASK) : ((flist[i] >> 1) & COORD_MASK);
        if (code == CODE_LONG) begin
          if (extreme) begin
            add_body_byte(ax == 0 ? 8'h7F : 8'h80);
            add_body_byte(ax == 0 ? 8'hFF : 8'h00);
          end else begin
            add_body_byte(8'($urandom_range(0, 255)));
            add_body_byte(8'($urandom_range(0, 255)));
          end
        end else if (code != CODE_SAME) begin
          add_body_byte(extreme ? 8'hFF : 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic test_basic_glyphs();
    build_glyph(5, 2, 3, 30, -1, 0);
    send_body(2, body_q.size());
    build_glyph(1, 1, 0, 0, -1, 0);
    send_body(1, body_q.size());
    build_glyph(12, 3, 1, 50, -1, 0);
    send_body(3, body_q.size());
  endtask

  task automatic test_zero_contours();
    build_glyph(1, 0, 2, 0, -1, 0);
    send_body(0, body_q.size());
    build_glyph(1, 0, 0, 0, -1, 0);
    send_body(0, body_q.size());
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0, 10'h3FF);
    send_byte(8'hFF, 1'b0, 10'h000);
  endtask

  task automatic test_overflow();
    // Too many plain flags, sent up to the flag that overflows the store,
    // then a repeat count that runs past the store.
    build_glyph(70, 1, 0, 0, -1, 0);
    send_body(1, 4 + MAX_POINTS + 1);
    body_q = '{8'h00, 8'h32, 8'h00, 8'h00, 8'h08, 8'hFF};
    send_body(1, body_q.size());
  endtask

  task automatic test_saturation();
    build_glyph(8, 1, 0, 0, 8'h08, 1);
    send_body(1, body_q.size());
  endtask

  task automatic test_result_cap();
    // One repeat byte makes 128 byteless points; the rest drains on the next byte.
    build_glyph(64, 1, 0, 0, 8'h39, 0);
    send_body(1, body_q.size());
    send_byte(8'h5A, 1'b0, 10'h000);
  endtask

  task automatic test_restart_mid_glyph();
    build_glyph(10, 2, 0, 20, -1, 0);
    send_body(2, body_q.size() - 3);
    send_byte(8'hA5, 1'b1, 10'h3FF);
    send_byte(8'h5A, 1'b0, 10'h2AA);
  endtask

  task automatic test_random_glyphs();
    int sel, npts, ncont, len;
    while (bytes_sent < RandomBytes + 60) begin
      no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(1, 100);
      npts = ($urandom_range(1, 20) == 1) ? $urandom_range(20, 64) : $urandom_range(1, 10);
      ncont = $urandom_range(1, (npts < 4) ? npts : 4);
      if (sel <= 75) begin
        build_glyph(npts, ncont, $urandom_range(0, 3), 30, -1, 0);
        send_body(ncont, body_q.size());
      end else if (sel <= 88) begin
        build_glyph(npts, ncont, $urandom_range(0, 3), 30, -1, 0);
        send_body(ncont, $urandom_range(1, body_q.size()));
      end else if (sel <= 95) begin
        len = $urandom_range(1, 8);
        body_q.delete();
        repeat (len) add_body_byte(8'($urandom_range(0, 255)));
        send_body(10'($urandom_range(0, 1023)), len);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 10'($urandom_range(0, 1023)));
      end
    end
    no_idle = 0;
  endtask

  // Output side: random stall per item and a check of every transfer.
  int out_wait;
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_items.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item kind=%0d idx=%0d val=%0d", out_if.item_kind,
                   out_if.point_index, out_if.coord_value);
        end
      end else begin
        point_item_t e;
        e = expected_items.pop_front();
        if (out_if.item_kind != e.kind || out_if.point_index != e.idx ||
            out_if.coord_value != e.val || out_if.on_curve != e.on ||
            out_if.last_of_glyph != e.is_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("item mismatch: expected kind=%0d idx=%0d val=%0d on=%0d last=%0d",
                     e.kind, e.idx, e.val, e.on, e.is_last);
            $display("               actual   kind=%0d idx=%0d val=%0d on=%0d last=%0d",
                     out_if.item_kind, out_if.point_index, out_if.coord_value,
                     out_if.on_curve, out_if.last_of_glyph);
          end
        end
      end
      out_wait = no_idle ? 0 : $urandom_range(0, 16);
    end
    if (out_wait > 0) begin
      out_wait--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.glyph_start <= 1'b0;
    in_if.contour_count <= 10'h000;
    ph = DP_IDLE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_basic_glyphs();
    test_zero_contours();
    test_overflow();
    test_saturation();
    test_result_cap();
    test_restart_mid_glyph();
    test_random_glyphs();
    in_if.valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_items.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
